// File: rtl/ats_pkg.sv
// ---------------------------------------------------------------------------
// ats_pkg
// shared types and codes for the annealing tour step block
// ---------------------------------------------------------------------------
package ats_pkg;

  localparam int ENERGY_W = 39;
  localparam int COUNT_W  = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    REG_CITY_COUNT = 1'b0,
    REG_BETA       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  index;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [4:0]  tour_city;
    logic        use_reverse;
    logic [4:0]  seg_start;
    logic [4:0]  seg_count;
    logic [15:0] neg_log_uniform;
  } in_word_t;

  typedef struct packed {
    logic [38:0] energy_prev;
    logic [38:0] energy_cand;
    logic        accepted;
    logic [38:0] best_energy;
    logic        improved;
    logic [31:0] accepted_total;
    logic [31:0] attempted_total;
    logic [4:0]  best_city;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATHER,
    ST_PERM_I,
    ST_PERM_J,
    ST_PERM_SWAP,
    ST_REVERSE,
    ST_SCATTER,
    ST_ENERGY,
    ST_DIVIDE,
    ST_COMMIT,
    ST_COPY,
    ST_RESULT,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic capture;
    logic gather;
    logic perm_i;
    logic perm_j;
    logic perm_swap;
    logic rev_step;
    logic scatter;
    logic energy;
    logic div_start;
    logic div_step;
    logic commit;
    logic copy;
    logic result;
    logic read;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic perm_i_done;
    logic perm_j_done;
    logic perm_wrap;
    logic rev_done;
    logic need_div;
    logic div_done;
    logic need_copy;
    logic rev_mode;
  } stat_t;

endpackage

// File: rtl/annealing_tour_step.sv
// ---------------------------------------------------------------------------
// annealing_tour_step
// simulated annealing step on a closed tour with metropolis acceptance
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load word writes
// one city and tour entry, keeps busy low and gives no result.
// A step word folds the segment start into range (only when it lies past
// the last city), gathers the segment, mutates it, scatters it, walks both
// tours for the energy, runs a restoring divider when the energy rose and
// beta is nonzero, then commits and, when the step is accepted or improves
// the best energy, copies. A readout word streams n results on consecutive
// cycles, the first registered out of the read state that follows the word.
// Each result shows on out_* for one cycle with out_valid; the receiver
// cannot stall. Reset clears tour, best tour and counters and sets best
// energy to all ones; the configuration registers return to 32 cities and
// beta 2^24.
// ---------------------------------------------------------------------------
module annealing_tour_step import ats_pkg::*; #(
  parameter int MAX_CITIES = 32,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [5:0]  city_count_r;
  logic [31:0] beta_r;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= 6'd32;
      beta_r       <= 32'd16777216;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CITY_COUNT: city_count_r <= cfg_data[5:0];
        REG_BETA:       beta_r       <= cfg_data;
        default:        beta_r       <= beta_r;
      endcase
    end
  end

  ats_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy_in(busy),
    .func(func_t'(in_word.func)),
    .stat, .ctrl, .busy
  );

  ats_dp #(.MAX_CITIES(MAX_CITIES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .ctrl, .in_word,
    .city_count(city_count_r), .beta(beta_r),
    .stat, .out_valid, .out_word
  );

endmodule

// File: rtl/ats_ctrl.sv
// ---------------------------------------------------------------------------
// ats_ctrl
// sequencer for load, step and readout words
// ---------------------------------------------------------------------------
module ats_ctrl import ats_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   busy_in,
  input  func_t  func,
  input  stat_t  stat,
  output ctrl_t  ctrl,
  output logic   busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !busy_in) begin
          case (func)
            FUNC_STEP: state_nxt = ST_GATHER;
            FUNC_READ: state_nxt = ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GATHER:    if (stat.walk_done) state_nxt = stat.rev_mode ? ST_REVERSE : ST_PERM_I;
      ST_PERM_I: begin
        if (stat.perm_i_done) state_nxt = stat.perm_wrap ? ST_REVERSE : ST_PERM_J;
      end
      ST_PERM_J:    if (stat.perm_j_done) state_nxt = ST_PERM_SWAP;
      ST_PERM_SWAP: state_nxt = ST_REVERSE;
      ST_REVERSE:   if (stat.rev_done) state_nxt = ST_SCATTER;
      ST_SCATTER:   if (stat.walk_done) state_nxt = ST_ENERGY;
      ST_ENERGY:    if (stat.walk_done) state_nxt = stat.need_div ? ST_DIVIDE : ST_COMMIT;
      ST_DIVIDE:    if (stat.div_done) state_nxt = ST_COMMIT;
      ST_COMMIT:    state_nxt = stat.need_copy ? ST_COPY : ST_RESULT;
      ST_COPY:      if (stat.walk_done) state_nxt = ST_RESULT;
      ST_RESULT:    state_nxt = ST_IDLE;
      ST_READ:      if (stat.walk_done) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.load    = start && !busy_in && (func == FUNC_LOAD);
        ctrl.capture = start && !busy_in;
      end
      ST_GATHER:    ctrl.gather    = 1'b1;
      ST_PERM_I:    ctrl.perm_i    = 1'b1;
      ST_PERM_J:    ctrl.perm_j    = 1'b1;
      ST_PERM_SWAP: ctrl.perm_swap = 1'b1;
      ST_REVERSE:   ctrl.rev_step  = 1'b1;
      ST_SCATTER:   ctrl.scatter   = 1'b1;
      ST_ENERGY: begin
        ctrl.energy    = 1'b1;
        ctrl.div_start = stat.walk_done;
      end
      ST_DIVIDE:    ctrl.div_step  = 1'b1;
      ST_COMMIT:    ctrl.commit    = 1'b1;
      ST_COPY:      ctrl.copy      = 1'b1;
      ST_RESULT:    ctrl.result    = 1'b1;
      ST_READ:      ctrl.read      = 1'b1;
      default:      ctrl = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.result |=> state_r == ST_IDLE) else $error("result not followed by idle");
  a_div_from_energy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> ($past(state_r) == ST_ENERGY || $past(state_r) == ST_DIVIDE))
    else $error("divide entered badly");
`endif

endmodule

// File: rtl/ats_dp.sv
// ---------------------------------------------------------------------------
// ats_dp
// tour storage, segment mutation, energy walk, divider and counters
// ---------------------------------------------------------------------------
module ats_dp import ats_pkg::*; #(
  parameter int MAX_CITIES = 32,
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctrl,
  input  in_word_t  in_word,
  input  logic [5:0]  city_count,
  input  logic [31:0] beta,
  output stat_t     stat,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int IW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CW = IW + 1;
  localparam int SQW = 2 * COORD_BITS;

  logic [4:0] tour_r  [MAX_CITIES];
  logic [4:0] cand_r  [MAX_CITIES];
  logic [4:0] best_r  [MAX_CITIES];
  logic [4:0] piece_r [MAX_CITIES];
  logic [IW-1:0] pos_r [MAX_CITIES];
  logic [COORD_BITS-1:0] xc_r [MAX_CITIES];
  logic [COORD_BITS-1:0] yc_r [MAX_CITIES];

  in_word_t    req_r;
  logic [CW-1:0] n_r, cnt_r, k_r, lo_r, hi_r, pi_r, pj_r, p_r;
  logic [38:0] e_old_r, e_new_r, low_r;
  logic [31:0] acc_cnt_r, att_cnt_r;
  logic        acc_r, imp_r, div_r;
  logic [47:0] rem_r;
  logic [47:0] quo_r;
  logic [5:0]  dcnt_r;
  logic [39:0] sum_old_r, sum_new_r;

  logic [CW-1:0] n_c, cnt_c, p_c;
  logic          p_wrap;
  logic [38:0] de;

  function automatic logic [38:0] sat39(input logic [39:0] v);
    return v[39] ? '1 : v[38:0];
  endfunction

  always_comb begin
    n_c = CW'(MAX_CITIES);
    if (city_count < 6'd3) n_c = CW'(3);
    else if (32'(city_count) < MAX_CITIES) n_c = CW'(city_count);
    cnt_c = CW'(in_word.seg_count);
    if (32'(in_word.seg_count) > 32'(n_c) - 1) cnt_c = n_c - CW'(1);
  end

  // segment start folded into 1..n-1 one subtraction per cycle
  assign p_wrap = (p_r >= n_r);

  // wrapped segment position
  always_comb begin
    p_c = p_r + CW'(1);
    if (p_c >= n_r) p_c = CW'(1);
  end

  function automatic logic [SQW:0] edge_cost(input logic [4:0] a, input logic [4:0] b,
      input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
      input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by);
    logic [COORD_BITS-1:0] x0, y0, x1, y1, dx, dy;
    logic [SQW-1:0] dxw, dyw;
    x0 = (32'(a) < MAX_CITIES) ? ax : '0;
    y0 = (32'(a) < MAX_CITIES) ? ay : '0;
    x1 = (32'(b) < MAX_CITIES) ? bx : '0;
    y1 = (32'(b) < MAX_CITIES) ? by : '0;
    dx = (x0 >= x1) ? x0 - x1 : x1 - x0;
    dy = (y0 >= y1) ? y0 - y1 : y1 - y0;
    dxw = SQW'(dx);
    dyw = SQW'(dy);
    return (SQW+1)'(dxw * dxw) + (SQW+1)'(dyw * dyw);
  endfunction

  logic [IW-1:0] ki, kn;
  logic [4:0] ot_a, ot_b, nt_a, nt_b;
  logic [SQW:0] ec_old, ec_new;
  always_comb begin
    ki = k_r[IW-1:0];
    kn = (k_r + CW'(1) == n_r) ? '0 : IW'(k_r + CW'(1));
    ot_a = tour_r[ki];
    ot_b = (k_r + CW'(1) == n_r) ? 5'd0 : tour_r[kn];
    nt_a = cand_r[ki];
    nt_b = (k_r + CW'(1) == n_r) ? 5'd0 : cand_r[kn];
    ec_old = edge_cost(ot_a, ot_b, xc_r[ot_a[IW-1:0]], yc_r[ot_a[IW-1:0]],
                       xc_r[ot_b[IW-1:0]], yc_r[ot_b[IW-1:0]]);
    ec_new = edge_cost(nt_a, nt_b, xc_r[nt_a[IW-1:0]], yc_r[nt_a[IW-1:0]],
                       xc_r[nt_b[IW-1:0]], yc_r[nt_b[IW-1:0]]);
  end

  logic walk_end;
  assign walk_end = (k_r + CW'(1) >= ((ctrl.gather || ctrl.scatter) ? cnt_r : n_r));

  logic [4:0] pa, pb, pc;
  always_comb begin
    pa = piece_r[IW'(pi_r - CW'(1))];
    pb = piece_r[pi_r[IW-1:0]];
    pc = piece_r[pj_r[IW-1:0]];
  end

  // running sums including the edge of this cycle
  logic [39:0] old_sat, new_sat;
  always_comb begin
    old_sat = sum_old_r + 40'(ec_old);
    new_sat = sum_new_r + 40'(ec_new);
  end

  assign de = e_new_r - e_old_r;

  logic [48:0] trial;
  assign trial = {rem_r, quo_r[47]} - {17'd0, beta};

  logic acc_c, imp_c;
  assign acc_c = div_r ? (48'(de) <= quo_r) : 1'b1;
  assign imp_c = e_new_r < low_r;

  always_comb begin
    stat = '0;
    if (ctrl.gather)       stat.walk_done = (cnt_r == '0) || (!p_wrap && walk_end);
    else if (ctrl.scatter) stat.walk_done = (cnt_r == '0) || walk_end;
    else                   stat.walk_done = walk_end;
    stat.perm_i_done = (pi_r == '0) || (pa < pb) || (cnt_r < CW'(2));
    stat.perm_wrap   = (pi_r == '0) || (cnt_r < CW'(2));
    stat.perm_j_done = pc > pa;
    stat.rev_done    = lo_r >= hi_r || cnt_r == '0;
    stat.need_div    = (sat39(new_sat) > sat39(old_sat)) && (beta != '0);
    stat.div_done    = dcnt_r == 6'd47;
    stat.need_copy   = acc_c || imp_c;
    stat.rev_mode    = req_r.use_reverse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CITIES; i++) begin
        tour_r[i] <= '0;
        best_r[i] <= '0;
      end
      low_r     <= '1;
      acc_cnt_r <= '0;
      att_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctrl.result || ctrl.read;
      if (ctrl.capture) begin
        req_r <= in_word;
        n_r   <= n_c;
        cnt_r <= cnt_c;
        k_r   <= '0;
        p_r   <= CW'(in_word.seg_start);
        for (int i = 0; i < MAX_CITIES; i++) cand_r[i] <= tour_r[i];
      end
      if (ctrl.load && 32'(in_word.index) < MAX_CITIES) begin
        xc_r[in_word.index[IW-1:0]] <= COORD_BITS'(in_word.x_value);
        yc_r[in_word.index[IW-1:0]] <= COORD_BITS'(in_word.y_value);
        tour_r[in_word.index[IW-1:0]] <= (in_word.index == '0) ? 5'd0 : in_word.tour_city;
      end
      if (ctrl.gather) begin
        if (p_wrap) begin
          p_r <= p_r - (n_r - CW'(1));
        end else begin
          piece_r[ki] <= tour_r[p_c[IW-1:0]];
          pos_r[ki]   <= p_c[IW-1:0];
          p_r   <= p_c;
          k_r   <= stat.walk_done ? '0 : k_r + CW'(1);
        end
        pi_r  <= cnt_r - CW'(1);
        lo_r  <= '0;
        hi_r  <= (cnt_r == '0) ? '0 : cnt_r - CW'(1);
        pj_r  <= cnt_r - CW'(1);
      end
      if (ctrl.perm_i && !stat.perm_i_done) pi_r <= pi_r - CW'(1);
      if (ctrl.perm_i && stat.perm_i_done && !stat.perm_wrap) lo_r <= pi_r;
      if (ctrl.perm_j && !stat.perm_j_done) pj_r <= pj_r - CW'(1);
      if (ctrl.perm_swap) begin
        piece_r[IW'(pi_r - CW'(1))] <= pc;
        piece_r[pj_r[IW-1:0]]       <= pa;
      end
      if (ctrl.rev_step && !stat.rev_done) begin
        piece_r[lo_r[IW-1:0]] <= piece_r[hi_r[IW-1:0]];
        piece_r[hi_r[IW-1:0]] <= piece_r[lo_r[IW-1:0]];
        lo_r <= lo_r + CW'(1);
        hi_r <= hi_r - CW'(1);
      end
      if (ctrl.rev_step && stat.rev_done) begin
        k_r <= '0;
      end
      if (ctrl.scatter) begin
        if (cnt_r != '0) cand_r[pos_r[ki]] <= piece_r[ki];
        k_r <= stat.walk_done ? '0 : k_r + CW'(1);
        sum_old_r <= '0;
        sum_new_r <= '0;
      end
      if (ctrl.energy) begin
        sum_old_r <= (sum_old_r[39]) ? sum_old_r : old_sat;
        sum_new_r <= (sum_new_r[39]) ? sum_new_r : new_sat;
        k_r <= stat.walk_done ? '0 : k_r + CW'(1);
      end
      if (ctrl.div_start) begin
        e_old_r <= sat39(old_sat);
        e_new_r <= sat39(new_sat);
        div_r   <= stat.need_div;
        rem_r   <= '0;
        quo_r   <= {req_r.neg_log_uniform, 32'd0} >> 16;
        dcnt_r  <= '0;
      end
      if (ctrl.div_step) begin
        if (!trial[48]) begin
          rem_r <= trial[47:0];
          quo_r <= {quo_r[46:0], 1'b1};
        end else begin
          rem_r <= {rem_r[46:0], quo_r[47]};
          quo_r <= {quo_r[46:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 6'd1;
      end
      if (ctrl.commit) begin
        acc_r <= acc_c;
        imp_r <= imp_c;
        if (imp_c) low_r <= e_new_r;
        if (acc_c && acc_cnt_r != '1) acc_cnt_r <= acc_cnt_r + 32'd1;
        if (att_cnt_r != '1) att_cnt_r <= att_cnt_r + 32'd1;
        k_r <= '0;
      end
      if (ctrl.copy) begin
        for (int i = 0; i < MAX_CITIES; i++) begin
          if (acc_r) tour_r[i] <= cand_r[i];
          if (imp_r) best_r[i] <= cand_r[i];
        end
        k_r <= n_r - CW'(1);
      end
      if (ctrl.result) begin
        out_word.energy_prev     <= e_old_r;
        out_word.energy_cand     <= e_new_r;
        out_word.accepted        <= acc_r;
        out_word.best_energy     <= low_r;
        out_word.improved        <= imp_r;
        out_word.accepted_total  <= acc_cnt_r;
        out_word.attempted_total <= att_cnt_r;
        out_word.best_city       <= '0;
        out_word.last            <= 1'b1;
      end
      if (ctrl.read) begin
        out_word.energy_prev     <= '0;
        out_word.energy_cand     <= '0;
        out_word.accepted        <= 1'b0;
        out_word.best_energy     <= '0;
        out_word.improved        <= 1'b0;
        out_word.accepted_total  <= '0;
        out_word.attempted_total <= '0;
        out_word.best_city       <= best_r[ki];
        out_word.last            <= stat.walk_done;
        k_r <= stat.walk_done ? '0 : k_r + CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_low_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= $past(low_r) || $past(!rst_n)) else $error("best energy rose");
  a_att_ge_acc: assert property (@(posedge clk) disable iff (!rst_n)
    att_cnt_r >= acc_cnt_r) else $error("accept count above attempt count");
  a_result_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.result |=> out_valid && out_word.last) else $error("step result malformed");
`endif

endmodule
